@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tile map collision checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/tmnc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmnc_pkg
// Types and constants shared by the tile map collision block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmnc_pkg;

  localparam int MAP_COLS_DEF = 64;
  localparam int MAP_ROWS_DEF = 32;

  // Opcodes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Passable tile codes
  localparam logic [7:0] CODE_EMPTY = 8'd0;
  localparam logic [7:0] CODE_PASS  = 8'd6;

  // Configuration registers
  localparam int          PADDR_W       = 3;
  localparam logic [0:0]  REG_TILE_SIZE = 1'b0;
  localparam logic [7:0]  TILE_SIZE_RST = 8'd32;

  // Datapath widths, sized for the largest map (256 x 256) and tile size 255
  localparam int PIX_W  = 16;  // tile pixel edge, unsigned
  localparam int CMP_W  = 18;  // signed compare width
  localparam int DIF_W  = 19;  // doubled-coordinate difference, signed
  localparam int SQ_W   = 36;  // square of a difference
  localparam int DIST_W = 37;  // squared distance
  localparam int EDGE_W = 15;  // output edge width

  typedef struct packed {
    logic start;  // new query: clear best, load rectangle
    logic row;    // multiplier squares the row offset
    logic issue;  // one tile read issued this cycle
    logic first;  // first tile of a row
    logic last;   // last tile of a row
  } scan_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic              hit;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
    logic [7:0]        code;
  } scan_res_t;

endpackage

@@ rtl/tmnc_map_ram.sv @@
// ----------------------------------------------------------------------------
// tmnc_map_ram
// Single write port, single registered read port tile code memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmnc_map_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tmnc_scan_unit.sv @@
// ----------------------------------------------------------------------------
// tmnc_scan_unit
// Per-tile overlap test and nearest-distance tracking around one shared
// squaring multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tmnc_scan_unit
  import tmnc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scan_ctrl_t              ctrl_i,
  input  logic [7:0]              tile_size_i,
  input  logic signed [15:0]      rect_left_i,
  input  logic signed [15:0]      rect_top_i,
  input  logic signed [15:0]      rect_right_i,
  input  logic signed [15:0]      rect_bottom_i,
  input  logic [7:0]              rd_data_i,
  output scan_res_t               status_o
);

  // Doubled centre of [lo, lo+s] minus doubled rectangle centre
  function automatic logic signed [DIF_W-1:0] axis_diff(
    input logic [PIX_W-1:0]      lo,
    input logic [7:0]            s,
    input logic signed [PIX_W:0] c2
  );
    logic [PIX_W:0] sum;
    sum = {lo, 1'b0} + (PIX_W+1)'(s);
    return $signed({2'b00, sum}) - $signed({{2{c2[PIX_W]}}, c2});
  endfunction

  // Scan position
  logic [PIX_W-1:0]        cl_q, ct_q;

  // Query rectangle
  logic signed [15:0]      rl_q, rt_q, rr_q, rb_q;
  logic signed [PIX_W:0]   rcx2_q, rcy2_q;

  // Stage 1: memory data arrives
  logic                    s1_v_q;
  logic [PIX_W-1:0]        s1_cl_q, s1_ct_q;

  // Stage 2: candidate, ready to square
  logic                    s2_v_q;
  logic signed [DIF_W-1:0] s2_dx_q;
  logic [PIX_W-1:0]        s2_cl_q, s2_ct_q;
  logic [7:0]              s2_code_q;

  // Stage 3: square done
  logic                    s3_v_q;
  logic [SQ_W-1:0]         sq_q;
  logic [PIX_W-1:0]        s3_cl_q, s3_ct_q;
  logic [7:0]              s3_code_q;
  logic [SQ_W-1:0]         dy2_q;

  // Best so far
  logic                    hit_q;
  logic [DIST_W-1:0]       best_q;
  logic [PIX_W-1:0]        best_cl_q, best_ct_q;
  logic [7:0]              best_code_q;

  logic [PIX_W:0]            cr, cb;
  logic signed [CMP_W-1:0]   cl_e, ct_e, cr_e, cb_e, rl_e, rt_e, rr_e, rb_e;
  logic                      solid, overlap;
  logic signed [DIF_W-1:0]   dx, dy, mult_a;
  logic signed [2*DIF_W-1:0] prod;
  logic [DIST_W-1:0]         cand_dist;
  logic                      better;
  logic [PIX_W:0]            br, bb;

  assign cr   = (PIX_W+1)'(s1_cl_q) + (PIX_W+1)'(tile_size_i);
  assign cb   = (PIX_W+1)'(s1_ct_q) + (PIX_W+1)'(tile_size_i);
  assign cl_e = $signed({2'b00, s1_cl_q});
  assign ct_e = $signed({2'b00, s1_ct_q});
  assign cr_e = $signed({1'b0, cr});
  assign cb_e = $signed({1'b0, cb});
  assign rl_e = CMP_W'(rl_q);
  assign rt_e = CMP_W'(rt_q);
  assign rr_e = CMP_W'(rr_q);
  assign rb_e = CMP_W'(rb_q);

  assign solid   = (rd_data_i != CODE_EMPTY) && (rd_data_i != CODE_PASS);
  // Inclusive edges: touching counts
  assign overlap = !((cl_e > rr_e) || (ct_e > rb_e) || (cr_e < rl_e) || (cb_e < rt_e));

  assign dx = axis_diff(s1_cl_q, tile_size_i, rcx2_q);
  assign dy = axis_diff(ct_q, tile_size_i, rcy2_q);

  // Shared squarer: row offset at row start, tile offset otherwise
  assign mult_a = ctrl_i.row ? dy : s2_dx_q;
  assign prod   = mult_a * mult_a;

  assign cand_dist = DIST_W'(sq_q) + DIST_W'(dy2_q);
  assign better    = s3_v_q && (!hit_q || (cand_dist < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      s1_v_q <= ctrl_i.issue;
      s2_v_q <= s1_v_q && solid && overlap;
      s3_v_q <= s2_v_q;
      if (ctrl_i.start) begin
        hit_q <= 1'b0;
      end else if (better) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cl_q   <= '0;
      ct_q   <= '0;
      rl_q   <= rect_left_i;
      rt_q   <= rect_top_i;
      rr_q   <= rect_right_i;
      rb_q   <= rect_bottom_i;
      rcx2_q <= (PIX_W+1)'(rect_left_i) + (PIX_W+1)'(rect_right_i);
      rcy2_q <= (PIX_W+1)'(rect_top_i) + (PIX_W+1)'(rect_bottom_i);
    end else if (ctrl_i.issue) begin
      if (ctrl_i.last) begin
        cl_q <= '0;
        ct_q <= ct_q + PIX_W'(tile_size_i);
      end else begin
        cl_q <= cl_q + PIX_W'(tile_size_i);
      end
    end

    s1_cl_q   <= cl_q;
    s1_ct_q   <= ct_q;
    s2_dx_q   <= dx;
    s2_cl_q   <= s1_cl_q;
    s2_ct_q   <= s1_ct_q;
    s2_code_q <= rd_data_i;
    sq_q      <= prod[SQ_W-1:0];
    s3_cl_q   <= s2_cl_q;
    s3_ct_q   <= s2_ct_q;
    s3_code_q <= s2_code_q;

    // Row square sits in sq_q while the first tile of the row issues
    if (ctrl_i.first) begin
      dy2_q <= sq_q;
    end

    if (better) begin
      best_q      <= cand_dist;
      best_cl_q   <= s3_cl_q;
      best_ct_q   <= s3_ct_q;
      best_code_q <= s3_code_q;
    end
  end

  assign br = (PIX_W+1)'(best_cl_q) + (PIX_W+1)'(tile_size_i);
  assign bb = (PIX_W+1)'(best_ct_q) + (PIX_W+1)'(tile_size_i);

  always_comb begin
    status_o        = '0;
    status_o.busy   = s1_v_q || s2_v_q || s3_v_q;
    status_o.hit    = hit_q;
    if (hit_q) begin
      status_o.left   = best_cl_q[EDGE_W-1:0];
      status_o.top    = best_ct_q[EDGE_W-1:0];
      status_o.right  = br[EDGE_W-1:0];
      status_o.bottom = bb[EDGE_W-1:0];
      status_o.code   = best_code_q;
    end
  end

endmodule

@@ rtl/tile_map_nearest_collision.sv @@
// ----------------------------------------------------------------------------
// tile_map_nearest_collision
// Tile map store with a nearest-overlapping-solid-tile rectangle query.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one word per item: op 0 writes
// tile_value at (tile_col, tile_row), op 1 queries the rectangle. Every word
// yields exactly one result word on the output channel (out_valid_o/
// out_ready_i); a write or a miss returns all zeros.
// A write's zero result is loaded into the result register when the write is
// taken and is valid the next cycle. A query walks the map row by row through
// one squaring multiplier: for each row ST_ROW squares the row offset, ST_SCAN
// issues the tiles, ST_DRAIN waits for the compare pipeline to empty, and
// ST_DONE loads the result once the result register is free. No new word is
// taken during a query. After reset the map is cleared one entry per cycle,
// with in_ready_o low; the APB port works throughout.
// A stalled receiver holds the result register; a finished query waits for
// it to drain, and a write is taken only when the result register is free.
// tile_pixel_size sits at APB byte address 0, reset value 32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_map_nearest_collision
  import tmnc_pkg::*;
#(
  parameter int MAP_COLS = MAP_COLS_DEF,
  parameter int MAP_ROWS = MAP_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [5:0]         tile_col_i,
  input  logic [4:0]         tile_row_i,
  input  logic [7:0]         tile_value_i,
  input  logic signed [15:0] rect_left_i,
  input  logic signed [15:0] rect_top_i,
  input  logic signed [15:0] rect_right_i,
  input  logic signed [15:0] rect_bottom_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [14:0]        hit_left_o,
  output logic [14:0]        hit_top_o,
  output logic [14:0]        hit_right_o,
  output logic [14:0]        hit_bottom_o,
  output logic [7:0]         hit_code_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int DEPTH  = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int X_W    = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
  localparam int Y_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] addr_q;
  logic [X_W-1:0]    x_q;
  logic [Y_W-1:0]    y_q;
  logic [7:0]        tile_size_q;

  logic              out_valid_q;
  logic              out_hit_q;
  logic [EDGE_W-1:0] out_left_q, out_top_q, out_right_q, out_bottom_q;
  logic [7:0]        out_code_q;

  logic              in_acc, out_free, cfg_wr, wr_in_map, last_col, last_row;
  logic              out_load;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, wr_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  scan_ctrl_t        ctrl;
  scan_res_t         status;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_col   = (x_q == X_W'(MAP_COLS - 1));
  assign last_row   = (y_q == Y_W'(MAP_ROWS - 1));

  // Result register loads on a taken write or a finished query
  assign out_load   = (in_acc && (op_i == OP_WRITE)) || ((state_q == ST_DONE) && out_free);

  assign wr_in_map  = (int'(tile_col_i) < MAP_COLS) && (int'(tile_row_i) < MAP_ROWS);
  assign wr_addr    = ADDR_W'(int'(tile_row_i) * MAP_COLS + int'(tile_col_i));

  // Clearing pass owns the write port until it is done
  assign ram_we    = (state_q == ST_CLEAR) || (in_acc && (op_i == OP_WRITE) && wr_in_map);
  assign ram_waddr = (state_q == ST_CLEAR) ? addr_q : wr_addr;
  assign ram_wdata = (state_q == ST_CLEAR) ? CODE_EMPTY : tile_value_i;

  assign ctrl.start = in_acc && (op_i == OP_QUERY);
  assign ctrl.row   = (state_q == ST_ROW);
  assign ctrl.issue = (state_q == ST_SCAN);
  assign ctrl.first = (state_q == ST_SCAN) && (x_q == '0);
  assign ctrl.last  = last_col;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_TILE_SIZE) ? {24'd0, tile_size_q} : 32'd0;

  tmnc_map_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  tmnc_scan_unit u_scan_unit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .tile_size_i   (tile_size_q),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_right_i  (rect_right_i),
    .rect_bottom_i (rect_bottom_i),
    .rd_data_i     (ram_rdata),
    .status_o      (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      addr_q       <= '0;
      x_q          <= '0;
      y_q          <= '0;
      tile_size_q  <= TILE_SIZE_RST;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_left_q   <= '0;
      out_top_q    <= '0;
      out_right_q  <= '0;
      out_bottom_q <= '0;
      out_code_q   <= '0;
    end else begin
      if (cfg_wr && (paddr[PADDR_W-1:2] == REG_TILE_SIZE)) begin
        tile_size_q <= pwdata[7:0];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          if (addr_q == ADDR_W'(DEPTH - 1)) begin
            addr_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (op_i == OP_QUERY) begin
              addr_q  <= '0;
              x_q     <= '0;
              y_q     <= '0;
              state_q <= ST_ROW;
            end else begin
              // write word: zero result
              out_hit_q    <= 1'b0;
              out_left_q   <= '0;
              out_top_q    <= '0;
              out_right_q  <= '0;
              out_bottom_q <= '0;
              out_code_q   <= '0;
            end
          end
        end
        ST_ROW: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          addr_q <= addr_q + 1'b1;
          if (last_col) begin
            x_q     <= '0;
            state_q <= ST_DRAIN;
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          // wait until the last tile of the row has been compared
          if (!status.busy) begin
            if (last_row) begin
              state_q <= ST_DONE;
            end else begin
              y_q     <= y_q + 1'b1;
              state_q <= ST_ROW;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_hit_q    <= status.hit;
            out_left_q   <= status.left;
            out_top_q    <= status.top;
            out_right_q  <= status.right;
            out_bottom_q <= status.bottom;
            out_code_q   <= status.code;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign hit_left_o   = out_left_q;
  assign hit_top_o    = out_top_q;
  assign hit_right_o  = out_right_q;
  assign hit_bottom_o = out_bottom_q;
  assign hit_code_o   = out_code_q;

endmodule

@@ rtl/tmnc_checker.sv @@
// ----------------------------------------------------------------------------
// tmnc_checker
// Port-level checks for the tile map collision block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmnc_checker
  import tmnc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        op_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [14:0] hit_left_o,
  input logic [14:0] hit_top_o,
  input logic [14:0] hit_right_o,
  input logic [14:0] hit_bottom_o,
  input logic [7:0]  hit_code_o
);

  // A miss carries no tile
  `ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, out_valid_o && !hit_o, (hit_left_o == '0) && (hit_top_o == '0) && (hit_right_o == '0) && (hit_bottom_o == '0) && (hit_code_o == '0))

  // A hit never reports a passable code
  `ASSERT_IMPL(a_hit_solid, clk_i, rst_ni, out_valid_o && hit_o, (hit_code_o != CODE_EMPTY) && (hit_code_o != CODE_PASS))

  // A query occupies the block: no word taken right after one
  `ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (op_i == OP_QUERY), !in_ready_o)

  // Stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(hit_o) && $stable(hit_code_o) && $stable(hit_left_o))

endmodule

bind tile_map_nearest_collision tmnc_checker u_tmnc_checker (.*);

@@ tb/sv/tile_map_nearest_collision_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_map_nearest_collision_test
// Loads tile words into the map and fires rectangle queries at it across
// several tile sizes, with and without gaps on the input and output sides.
// Every word is predicted at acceptance by a local copy of the map, and
// every result word is compared field by field, in order.
// ----------------------------------------------------------------------------

module tile_map_nearest_collision_test
  import tmnc_pkg::*;
();

  typedef struct {
    logic               op;
    logic [5:0]         col;
    logic [4:0]         row;
    logic [7:0]         value;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
  } tile_word_t;

  typedef struct {
    logic        hit;
    logic [14:0] left;
    logic [14:0] top;
    logic [14:0] right;
    logic [14:0] bottom;
    logic [7:0]  code;
  } hit_word_t;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_e;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               op_i          = OP_WRITE;
  logic [5:0]         tile_col_i    = '0;
  logic [4:0]         tile_row_i    = '0;
  logic [7:0]         tile_value_i  = '0;
  logic signed [15:0] rect_left_i   = '0;
  logic signed [15:0] rect_top_i    = '0;
  logic signed [15:0] rect_right_i  = '0;
  logic signed [15:0] rect_bottom_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               hit_o;
  logic [14:0]        hit_left_o;
  logic [14:0]        hit_top_o;
  logic [14:0]        hit_right_o;
  logic [14:0]        hit_bottom_o;
  logic [7:0]         hit_code_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  tile_map_nearest_collision dut (.*);

  // Local copy of the map and the tile size
  logic [7:0] tile_codes [MAP_ROWS_DEF*MAP_COLS_DEF];
  logic [7:0] tile_size;

  tile_word_t map_words[$];
  hit_word_t  nearest_hits[$];
  tile_word_t shown_word;
  int         solid_spots[$];

  int words_queued = 0;
  int issued_count = 0;
  int taken_count  = 0;
  int results_seen = 0;
  int n_writes     = 0;
  int n_queries    = 0;
  int n_hits       = 0;
  int errors       = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int odd_size;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Apply one word to the local map and return the result word it yields.
  function automatic hit_word_t nearest_tile(tile_word_t w);
    hit_word_t res;
    longint    s, cx2, cy2, cl, ct, cr, cb, dx, dy, d, best;
    logic [7:0] code;
    logic      found;
    int        r, c;
    res = '{default: '0};
    if (w.op == OP_WRITE) begin
      if (int'(w.col) < MAP_COLS_DEF && int'(w.row) < MAP_ROWS_DEF)
        tile_codes[int'(w.row) * MAP_COLS_DEF + int'(w.col)] = w.value;
      return res;
    end
    s     = longint'(tile_size);
    cx2   = longint'(w.left) + longint'(w.right);
    cy2   = longint'(w.top) + longint'(w.bottom);
    found = 1'b0;
    best  = 0;
    for (r = 0; r < MAP_ROWS_DEF; r++) begin
      for (c = 0; c < MAP_COLS_DEF; c++) begin
        code = tile_codes[r * MAP_COLS_DEF + c];
        if (code == CODE_EMPTY || code == CODE_PASS) continue;
        cl = c * s;
        cr = cl + s;
        ct = r * s;
        cb = ct + s;
        // touching edges count as overlap
        if (cl > w.right || ct > w.bottom || cr < w.left || cb < w.top) continue;
        dx = (cl + cr) - cx2;
        dy = (ct + cb) - cy2;
        d  = dx * dx + dy * dy;
        // strict compare keeps the first tile on a tie
        if (!found || d < best) begin
          found      = 1'b1;
          best       = d;
          res.hit    = 1'b1;
          res.left   = 15'(cl);
          res.top    = 15'(ct);
          res.right  = 15'(cr);
          res.bottom = 15'(cb);
          res.code   = code;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Input side: hold a word until taken, then load the next or idle; also drive out_ready_i with random gaps.
  always @(negedge clk_i) begin : drive_words
    tile_word_t nxt;
    if (!in_valid_i || taken_count == issued_count) begin
      if (map_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = map_words.pop_front();
        shown_word    <= nxt;
        op_i          <= nxt.op;
        tile_col_i    <= nxt.col;
        tile_row_i    <= nxt.row;
        tile_value_i  <= nxt.value;
        rect_left_i   <= nxt.left;
        rect_top_i    <= nxt.top;
        rect_right_i  <= nxt.right;
        rect_bottom_i <= nxt.bottom;
        in_valid_i    <= 1'b1;
        issued_count++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk_i) begin : watch_words
    hit_word_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      nearest_hits.push_back(nearest_tile(shown_word));
      if (shown_word.op == OP_WRITE) n_writes++;
      else n_queries++;
      taken_count++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (nearest_hits.size() == 0) begin
        report_mismatch("result word with no word outstanding");
      end else begin
        want = nearest_hits.pop_front();
        check_field("hit", 16'(hit_o), 16'(want.hit));
        check_field("hit_left", 16'(hit_left_o), 16'(want.left));
        check_field("hit_top", 16'(hit_top_o), 16'(want.top));
        check_field("hit_right", 16'(hit_right_o), 16'(want.right));
        check_field("hit_bottom", 16'(hit_bottom_o), 16'(want.bottom));
        check_field("hit_code", 16'(hit_code_o), 16'(want.code));
        if (want.hit) n_hits++;
      end
      results_seen++;
    end
  end

  task automatic queue_write(logic [5:0] col, logic [4:0] row, logic [7:0] code);
    tile_word_t w;
    w.op     = OP_WRITE;
    w.col    = col;
    w.row    = row;
    w.value  = code;
    w.left   = 16'($urandom);
    w.top    = 16'($urandom);
    w.right  = 16'($urandom);
    w.bottom = 16'($urandom);
    if (code != CODE_EMPTY && code != CODE_PASS)
      solid_spots.push_back(int'(row) * MAP_COLS_DEF + int'(col));
    map_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  task automatic queue_query(int l, int t, int r, int b);
    tile_word_t w;
    w.op     = OP_QUERY;
    w.col    = 6'($urandom);
    w.row    = 5'($urandom);
    w.value  = 8'($urandom);
    w.left   = clip16(l);
    w.top    = clip16(t);
    w.right  = clip16(r);
    w.bottom = clip16(b);
    map_words.push_back(w);
    words_queued++;
  endtask

  // Random tile writes and queries: mostly rectangles around solid tiles; some anywhere, some inverted.
  task automatic queue_random(int n);
    int i, pick, s, span, spot, cx, cy, l, t, r, b;
    logic [7:0] code;
    s = int'(tile_size);
    span = 3 * s + 2;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 58) begin
        pick = $urandom_range(9);
        code = (pick == 0) ? CODE_EMPTY :
               (pick == 1) ? CODE_PASS  : 8'($urandom_range(1, 255));
        queue_write(6'($urandom), 5'($urandom), code);
      end else begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          queue_query(int'(16'($urandom)) - 32768, int'(16'($urandom)) - 32768,
                      int'(16'($urandom)) - 32768, int'(16'($urandom)) - 32768);
        end else begin
          if (pick > 2 && solid_spots.size() != 0) begin
            spot = solid_spots[$urandom_range(solid_spots.size() - 1)];
            cx = (spot % MAP_COLS_DEF) * s + int'($urandom_range(0, s));
            cy = (spot / MAP_COLS_DEF) * s + int'($urandom_range(0, s));
          end else begin
            cx = int'($urandom_range(0, (MAP_COLS_DEF + 2) * s)) - s;
            cy = int'($urandom_range(0, (MAP_ROWS_DEF + 2) * s)) - s;
          end
          l = cx - int'($urandom_range(0, span));
          r = cx + int'($urandom_range(0, span));
          t = cy - int'($urandom_range(0, span));
          b = cy + int'($urandom_range(0, span));
          // swap the horizontal edges to invert the rectangle
          if (pick == 1) queue_query(r + 1, t, l, b);
          else queue_query(l, t, r, b);
        end
      end
    end
  endtask

  task automatic write_tile_size(logic [7:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(REG_TILE_SIZE) << 2;
    pwdata  <= {24'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tile_size = v;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_gaps(gap_mode_e mode);
    case (mode)
      GAP_NONE: begin send_gap_pct = 0;  recv_gap_pct = 0;  end
      GAP_SEND: begin send_gap_pct = 53; recv_gap_pct = 0;  end
      GAP_RECV: begin send_gap_pct = 0;  recv_gap_pct = 53; end
      default:  begin send_gap_pct = 30; recv_gap_pct = 30; end
    endcase
  endtask

  task automatic wait_results();
    while (results_seen != words_queued) @(negedge clk_i);
  endtask

  initial begin
    tile_size = TILE_SIZE_RST;
    foreach (tile_codes[i]) tile_codes[i] = '0;
    odd_size = $urandom_range(2, 254);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words at the reset tile size of 32
    set_gaps(GAP_NONE);
    queue_query(-32768, -32768, 32767, 32767);
    queue_write(6'd0, 5'd0, 8'd5);
    queue_write(6'd63, 5'd31, 8'd255);
    queue_write(6'd1, 5'd0, CODE_PASS);
    queue_write(6'd10, 5'd5, 8'd1);
    queue_query(-32768, -32768, 32767, 32767);
    queue_query(32, 16, 32, 16);
    queue_query(64, 0, 64, 31);
    queue_query(40, 0, 0, 40);
    queue_query(2016, 992, 2048, 1024);
    queue_query(32767, 32767, 32767, 32767);
    queue_query(-32768, -32768, -32768, -32768);
    queue_write(6'd4, 5'd4, 8'd7);
    queue_write(6'd6, 5'd4, 8'd8);
    queue_query(150, 140, 202, 150);
    queue_write(6'd0, 5'd0, CODE_EMPTY);
    queue_query(0, 0, 40, 40);
    queue_write(6'd63, 5'd31, CODE_PASS);
    queue_query(2016, 992, 2048, 1024);
    queue_random(40);
    wait_results();

    set_gaps(GAP_SEND);
    write_tile_size(8'd1);
    queue_random(50);
    wait_results();

    set_gaps(GAP_RECV);
    write_tile_size(8'd255);
    queue_random(50);
    wait_results();

    // every tile collapses onto the origin
    set_gaps(GAP_BOTH);
    write_tile_size(8'd0);
    queue_query(-5, -5, 5, 5);
    queue_query(1, 1, 10, 10);
    queue_query(0, 0, 0, 0);
    queue_random(35);
    wait_results();

    write_tile_size(8'(odd_size));
    queue_random(50);
    wait_results();

    set_gaps(GAP_NONE);
    write_tile_size(TILE_SIZE_RST);
    queue_random(45);
    wait_results();

    repeat (16) @(posedge clk_i);
    if (nearest_hits.size() != 0) report_mismatch("result words never arrived");
    $display("Ran %0d tile writes and %0d queries (%0d hits) at tile sizes 32, 1, 255, 0, %0d,",
             n_writes, n_queries, n_hits, odd_size);
    $display("with and without gaps on the input and output sides; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
